// ===== hdl/deq_pkg.sv =====
// Types, constants and index helpers shared by the double-ended queue.
package deq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int VAL_W = 32;
    localparam int FUNC_W = 3;
    localparam int STAT_W = 2;

    // Packed widths of the two channels, rounded up to whole bytes.
    localparam int S_RAW_W = FUNC_W + VAL_W;
    localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W = 2 * VAL_W + CNT_W + 1 + STAT_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FN_QUERY = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FN_PUSH_BACK = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FN_POP_FRONT = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FN_POP_BACK = FUNC_W'(4);

    localparam logic [STAT_W-1:0] ST_OK = STAT_W'(0);
    localparam logic [STAT_W-1:0] ST_UNDER = STAT_W'(1);
    localparam logic [STAT_W-1:0] ST_OVER = STAT_W'(2);

    localparam logic [VAL_W-1:0] EMPTY_WORD = '1;

    // Ring position a + b, for a below DEPTH and b at most DEPTH.
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + SUM_W'(b);
        if (s >= SUM_W'(DEPTH)) begin
            s = s - SUM_W'(DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    // Ring position one before a.
    function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
        logic [IDX_W-1:0] r;
        if (a == '0) begin
            r = IDX_W'(DEPTH - 1);
        end else begin
            r = a - IDX_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values held in a ring in one memory.
// A request is accepted in IDLE, where the pointers update and a push writes its slot;
// the READ state registers the slot memory reads and LOAD registers the result on the
// output, waiting while an earlier result is unaccepted. Requests are taken only in IDLE.
// A result waiting on the output does not hold back the next request's update.
// Reset (aresetn low at a clock edge) empties the queue; slot contents are kept.
module double_ended_queue import deq_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // func [2:0], value [34:3], zero fill above
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // front_value, back_value, entry_count, is_empty, status, from bit 0 up
    output logic [M_DATA_W-1:0]  m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_LOAD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic [VAL_W-1:0]  mem [DEPTH];
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  rd_back_addr;
    logic [VAL_W-1:0]  rd_front_reg, rd_back_reg;

    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic              out_load;

    logic [FUNC_W-1:0] in_func;
    logic [VAL_W-1:0]  in_value;
    logic              accept;
    logic              full, empty;

    assign in_func  = s_tdata[FUNC_W-1:0];
    assign in_value = s_tdata[FUNC_W+VAL_W-1:FUNC_W];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    // Pointer and count update; a push writes its slot in the same cycle.
    always_comb begin
        front_next  = front_reg;
        count_next  = count_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = ring_add(front_reg, count_reg);
        if (accept) begin
            status_next = ST_OK;
            case (in_func)
                FN_PUSH_BACK, FN_PUSH_FRONT: begin
                    if (full) begin
                        status_next = ST_OVER;
                    end else begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (in_func == FN_PUSH_FRONT) begin
                            front_next = ring_dec(front_reg);
                            wr_addr    = ring_dec(front_reg);
                        end
                    end
                end
                FN_POP_FRONT, FN_POP_BACK: begin
                    if (empty) begin
                        status_next = ST_UNDER;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        if (in_func == FN_POP_FRONT) begin
                            front_next = ring_add(front_reg, CNT_W'(1));
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The write lands with the pointer update, before the READ-state reads, so no bypass is needed.
    assign rd_back_addr = ring_add(front_reg, count_reg - CNT_W'(1));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= in_value;
        end
        rd_front_reg <= mem[front_reg];
        rd_back_reg  <= mem[rd_back_addr];
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            front_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        if (out_load) begin
            m_tdata_reg <= M_DATA_W'({status_reg,
                                      empty,
                                      count_reg,
                                      empty ? EMPTY_WORD : rd_back_reg,
                                      empty ? EMPTY_WORD : rd_front_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
